// File: rtl/core/led_blink_ramp_controller_top_defines.svh
// ============================================================================
// LED blink/ramp controller assertion macros
// Concurrent check macros for the controller; compiled out with NO_ASSERTIONS.
// ============================================================================
`ifndef LED_BLINK_RAMP_CONTROLLER_TOP_DEFINES_SVH
`define LED_BLINK_RAMP_CONTROLLER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the cycle after the antecedent.
`define LBR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lbr check failed: next-cycle property");
// Consequent must hold in the same cycle as the antecedent.
`define LBR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lbr check failed: same-cycle property");
`else
`define LBR_ASSERT_NEXT(lbl, ante, cons)
`define LBR_ASSERT_SAME(lbl, ante, cons)
`endif
`endif

// File: rtl/core/lbr_pkg.sv
// ============================================================================
// LED blink/ramp controller package
// Field widths, command and state codes, and transaction structs.
// ============================================================================
package lbr_pkg;

    localparam int DEF_PATTERN_DEPTH = 8;
    localparam int DEF_TIME_BITS     = 16;

    localparam int MODE_W     = 3;
    localparam int DUR_W      = 16;
    localparam int PCT_W      = 8;
    localparam int ENTRY_W    = 3;
    localparam int CNT_W      = 4;
    localparam int LEVEL_W    = 10;
    localparam int STATE_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 10'd1000;
    localparam logic [PCT_W-1:0]   PCT_FULL   = 8'd100;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK          = 3'd0,
        MODE_ON            = 3'd1,
        MODE_OFF           = 3'd2,
        MODE_BLINK         = 3'd3,
        MODE_BLINK_TIMES   = 3'd4,
        MODE_LOAD_ENTRY    = 3'd5,
        MODE_START_PATTERN = 3'd6
    } mode_t;

    typedef enum logic [STATE_W-1:0] {
        ST_OFF   = 2'd0,
        ST_ON    = 2'd1,
        ST_BLINK = 2'd2
    } led_state_t;

    typedef enum logic [1:0] {
        ACT_OFF_END   = 2'd0,
        ACT_ON_END    = 2'd1,
        ACT_GOING_ON  = 2'd2,
        ACT_GOING_OFF = 2'd3
    } phase_act_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LOW = 1'd0,
        CFG_DIMMABLE   = 1'd1
    } cfg_index_t;

    typedef struct packed {
        logic active_low;
        logic dimmable;
    } lbr_cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DUR_W-1:0]   duration_ms;
        logic [PCT_W-1:0]   level_pct;
        logic [DUR_W-1:0]   ramp_ms;
        logic [DUR_W-1:0]   blink_on_ms;
        logic [DUR_W-1:0]   blink_off_ms;
        logic [PCT_W-1:0]   blink_low_pct;
        logic [ENTRY_W-1:0] entry_index;
        logic [CNT_W-1:0]   pattern_count;
    } lbr_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] duty_pm;
        logic [STATE_W-1:0] led_state;
        logic               ramping;
        logic               temporary;
        logic               error;
    } lbr_result_t;

endpackage

// File: rtl/core/lbr_in_stage.sv
// ============================================================================
// LED blink/ramp controller input register
// Holds one accepted command or tick until the core consumes it.
// ============================================================================
module lbr_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lbr_pkg::lbr_item_t s_item,
    input  logic               advance,
    output logic               item_valid,
    output lbr_pkg::lbr_item_t item
);
    import lbr_pkg::*;

    logic      valid_reg;
    lbr_item_t item_reg;

    // Take a new transaction whenever the slot is empty or drains this cycle.
    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/core/lbr_out_stage.sv
// ============================================================================
// LED blink/ramp controller result register
// Holds one result transaction until the receiver takes it.
// ============================================================================
module lbr_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  lbr_pkg::lbr_result_t result_in,
    output logic                 can_load,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lbr_pkg::lbr_result_t result
);
    import lbr_pkg::*;

    logic        valid_reg;
    lbr_result_t result_reg;

    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign m_valid = valid_reg;
    assign result  = result_reg;

endmodule

// File: rtl/core/lbr_core.sv
// ============================================================================
// LED blink/ramp controller core
// Controller state and the single-pass update for one command or tick.
// ============================================================================
module lbr_core #(
    parameter int PATTERN_DEPTH = lbr_pkg::DEF_PATTERN_DEPTH,
    parameter int TIME_BITS     = lbr_pkg::DEF_TIME_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lbr_pkg::lbr_cfg_t    cfg,
    input  logic                 fire,
    input  lbr_pkg::lbr_item_t   item,
    output lbr_pkg::lbr_result_t result
);
    import lbr_pkg::*;

    // Only slots reachable through entry_index need storage; others read zero.
    localparam int STORE_N = (PATTERN_DEPTH < (1 << ENTRY_W)) ? PATTERN_DEPTH
                                                              : (1 << ENTRY_W);
    localparam int SIDX_W  = (STORE_N > 1) ? $clog2(STORE_N) : 1;
    localparam logic [31:0] TIME_MAX32 = 32'((64'd1 << TIME_BITS) - 64'd1);
    localparam logic [20:0] RECIP_TEN   = 21'd205;
    localparam int          RECIP_SHIFT = 11;

    typedef logic [TIME_BITS-1:0] tm_t;
    typedef logic [LEVEL_W-1:0]   lvl_t;

    function automatic tm_t sat_time(logic [DUR_W-1:0] x);
        logic [31:0] x32;
        x32 = 32'(x);
        if (x32 > TIME_MAX32) begin
            sat_time = {TIME_BITS{1'b1}};
        end else begin
            sat_time = x32[TIME_BITS-1:0];
        end
    endfunction

    function automatic lvl_t pct_to_pm(logic [PCT_W-1:0] pct, logic al);
        logic [PCT_W-1:0] p;
        lvl_t             v;
        p = (pct > PCT_FULL) ? PCT_FULL : pct;
        v = LEVEL_W'(p) * 10'd10;
        pct_to_pm = al ? (LEVEL_FULL - v) : v;
    endfunction

    // Divide by ten through a reciprocal; exact for every 10-bit level.
    function automatic lvl_t tenth(lvl_t x);
        logic [20:0] prod;
        prod  = 21'(x) * RECIP_TEN;
        tenth = prod[RECIP_SHIFT+LEVEL_W-1:RECIP_SHIFT];
    endfunction

    // State registers
    led_state_t         cur_reg, cur_next;
    led_state_t         saved_reg, saved_next;
    phase_act_t         phase_reg, phase_next;
    lvl_t               now_reg, now_next;
    lvl_t               high_reg, high_next;
    lvl_t               low_reg, low_next;
    logic               temp_reg, temp_next;
    tm_t                dur_left_reg, dur_left_next;
    tm_t                ramp_period_reg, ramp_period_next;
    tm_t                ramp_left_reg, ramp_left_next;
    logic               ramp_run_reg, ramp_run_next;
    tm_t                on_len_reg, on_len_next;
    tm_t                off_len_reg, off_len_next;
    tm_t                blink_left_reg, blink_left_next;
    logic               blink_run_reg, blink_run_next;
    logic [DUR_W-1:0]   store_reg [STORE_N];
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               started_reg, started_next;

    // Working values of the update
    logic               err;
    logic               store_we;
    logic               lc_go, lc_on;
    logic [DUR_W-1:0]   lc_dur;
    logic [PCT_W-1:0]   lc_pct;
    logic [DUR_W-1:0]   lc_ramp;
    logic               bc_go, bc_keep;
    tm_t                bc_on, bc_off;
    logic [DUR_W-1:0]   bc_dur;
    logic [PCT_W-1:0]   bc_hi, bc_lo;
    logic               pn_go;
    logic [DUR_W-1:0]   pv;
    lvl_t               lvl, step;
    logic               up, done;
    logic [LEVEL_W:0]   sum;
    phase_act_t         end_act;

    always_comb begin
        cur_next         = cur_reg;
        saved_next       = saved_reg;
        phase_next       = phase_reg;
        now_next         = now_reg;
        high_next        = high_reg;
        low_next         = low_reg;
        temp_next        = temp_reg;
        dur_left_next    = dur_left_reg;
        ramp_period_next = ramp_period_reg;
        ramp_left_next   = ramp_left_reg;
        ramp_run_next    = ramp_run_reg;
        on_len_next      = on_len_reg;
        off_len_next     = off_len_reg;
        blink_left_next  = blink_left_reg;
        blink_run_next   = blink_run_reg;
        used_next        = used_reg;
        pos_next         = pos_reg;
        started_next     = started_reg;
        err      = 1'b0;
        store_we = 1'b0;
        lc_go    = 1'b0;
        lc_on    = 1'b0;
        lc_dur   = '0;
        lc_pct   = '0;
        lc_ramp  = '0;
        bc_go    = 1'b0;
        bc_keep  = 1'b0;
        bc_on    = '0;
        bc_off   = '0;
        bc_dur   = '0;
        bc_hi    = '0;
        bc_lo    = '0;
        pn_go    = 1'b0;
        pv       = '0;
        lvl      = '0;
        step     = tenth(high_reg);
        up       = 1'b0;
        done     = 1'b0;
        sum      = '0;
        end_act  = ACT_OFF_END;

        unique case (mode_t'(item.mode))
            MODE_TICK: begin
                // Ramp step first
                if (ramp_run_reg) begin
                    if (ramp_left_reg <= tm_t'(1)) begin
                        if (phase_reg == ACT_GOING_ON || phase_reg == ACT_GOING_OFF) begin
                            up      = (phase_reg == ACT_GOING_ON) ? !cfg.active_low
                                                                  : cfg.active_low;
                            end_act = (phase_reg == ACT_GOING_ON) ? ACT_ON_END : ACT_OFF_END;
                            if (up) begin
                                sum = {1'b0, now_reg} + {1'b0, step};
                                if (sum >= {1'b0, high_reg}) begin
                                    now_next = high_reg;
                                    done     = 1'b1;
                                end else begin
                                    now_next = sum[LEVEL_W-1:0];
                                end
                            end else begin
                                sum = {1'b0, low_reg} + {1'b0, step};
                                if ({1'b0, now_reg} <= sum) begin
                                    now_next = low_reg;
                                    done     = 1'b1;
                                end else begin
                                    now_next = now_reg - step;
                                end
                            end
                            if (done) begin
                                ramp_run_next = 1'b0;
                                phase_next    = end_act;
                            end else begin
                                ramp_left_next = ramp_period_reg;
                            end
                        end else begin
                            ramp_run_next = 1'b0;
                        end
                    end else begin
                        ramp_left_next = ramp_left_reg - tm_t'(1);
                    end
                end
                // Then blink phase change
                if (blink_run_reg) begin
                    if (blink_left_reg <= tm_t'(1)) begin
                        if (phase_next == ACT_ON_END) begin
                            now_next        = cfg.active_low ? high_reg : low_reg;
                            phase_next      = ACT_OFF_END;
                            blink_left_next = off_len_reg;
                        end else begin
                            now_next        = cfg.active_low ? low_reg : high_reg;
                            phase_next      = ACT_ON_END;
                            blink_left_next = on_len_reg;
                        end
                    end else begin
                        blink_left_next = blink_left_reg - tm_t'(1);
                    end
                end
                // Then the temporary duration: restore or advance the pattern
                if (temp_reg) begin
                    if (dur_left_reg <= tm_t'(1)) begin
                        blink_run_next = 1'b0;
                        ramp_run_next  = 1'b0;
                        temp_next      = 1'b0;
                        cur_next       = saved_reg;
                        if (used_reg != '0) begin
                            pn_go = 1'b1;
                        end else begin
                            case (saved_reg)
                                ST_OFF: begin
                                    now_next   = low_reg;
                                    phase_next = ACT_OFF_END;
                                end
                                ST_ON: begin
                                    now_next   = high_reg;
                                    phase_next = ACT_ON_END;
                                end
                                default: begin
                                    cur_next = ST_BLINK;
                                    bc_go    = 1'b1;
                                    bc_keep  = 1'b1;
                                    bc_on    = on_len_reg;
                                    bc_off   = off_len_reg;
                                end
                            endcase
                        end
                    end else begin
                        dur_left_next = dur_left_reg - tm_t'(1);
                    end
                end
            end
            MODE_ON, MODE_OFF: begin
                lc_go   = 1'b1;
                lc_on   = (mode_t'(item.mode) == MODE_ON);
                lc_dur  = item.duration_ms;
                lc_pct  = item.level_pct;
                lc_ramp = item.ramp_ms;
            end
            MODE_BLINK: begin
                bc_go  = 1'b1;
                bc_on  = sat_time(item.blink_on_ms);
                bc_off = sat_time(item.blink_off_ms);
                bc_dur = item.duration_ms;
                bc_hi  = item.level_pct;
                bc_lo  = item.blink_low_pct;
            end
            MODE_BLINK_TIMES: begin
                on_len_next  = sat_time(item.blink_on_ms);
                off_len_next = sat_time(item.blink_off_ms);
            end
            MODE_LOAD_ENTRY: begin
                store_we = (32'(item.entry_index) < STORE_N);
            end
            MODE_START_PATTERN: begin
                if (32'(item.pattern_count) > PATTERN_DEPTH) begin
                    err = 1'b1;
                end else begin
                    used_next    = item.pattern_count;
                    started_next = 1'b0;
                    pos_next     = '0;
                    pn_go        = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Advance to the next pattern entry: even entries on, odd entries off
        if (pn_go && used_next != '0) begin
            if (!started_next || ({1'b0, pos_next} + 5'd1 >= {1'b0, used_next})) begin
                pos_next = '0;
            end else begin
                pos_next = pos_next + 1'b1;
            end
            started_next = 1'b1;
            if (32'(pos_next) < STORE_N) begin
                pv = store_reg[pos_next[SIDX_W-1:0]];
            end
            lc_go  = 1'b1;
            lc_on  = !pos_next[0];
            lc_dur = pv;
            lc_pct = lc_on ? PCT_FULL : '0;
        end

        // On/off command
        if (lc_go) begin
            blink_run_next = 1'b0;
            ramp_run_next  = 1'b0;
            temp_next      = 1'b0;
            if (lc_dur != '0) begin
                temp_next     = 1'b1;
                saved_next    = cur_next;
                dur_left_next = sat_time(lc_dur);
            end
            cur_next = lc_on ? ST_ON : ST_OFF;
            if (lc_ramp == '0 || !cfg.dimmable) begin
                phase_next = lc_on ? ACT_ON_END : ACT_OFF_END;
                if (!cfg.dimmable) begin
                    lvl = ((lc_pct != '0) ^ cfg.active_low) ? LEVEL_FULL : '0;
                end else begin
                    lvl = pct_to_pm(lc_pct, cfg.active_low);
                end
                if (lc_on) begin
                    high_next = lvl;
                end else begin
                    low_next = lvl;
                end
                now_next = lvl;
            end else begin
                phase_next       = lc_on ? ACT_GOING_ON : ACT_GOING_OFF;
                ramp_run_next    = 1'b1;
                ramp_period_next = sat_time(lc_ramp);
                ramp_left_next   = sat_time(lc_ramp);
            end
        end

        // Blink command or blink restore
        if (bc_go) begin
            if (bc_on == '0 && bc_off == '0) begin
                err = 1'b1;
            end else begin
                ramp_run_next = 1'b0;
                temp_next     = 1'b0;
                on_len_next   = bc_on;
                off_len_next  = bc_off;
                if (bc_dur != '0) begin
                    temp_next     = 1'b1;
                    saved_next    = cur_next;
                    dur_left_next = sat_time(bc_dur);
                end
                cur_next   = ST_BLINK;
                phase_next = ACT_ON_END;
                if (!bc_keep) begin
                    if (!cfg.dimmable) begin
                        high_next = pct_to_pm(PCT_FULL, cfg.active_low);
                        low_next  = pct_to_pm('0, cfg.active_low);
                    end else begin
                        high_next = pct_to_pm(bc_hi, cfg.active_low);
                        low_next  = pct_to_pm(bc_lo, cfg.active_low);
                    end
                end
                now_next        = high_next;
                blink_run_next  = 1'b1;
                blink_left_next = bc_on;
            end
        end

        result.duty_pm   = cfg.dimmable ? now_next
                                        : ((now_next >= LEVEL_FULL) ? LEVEL_FULL : '0);
        result.led_state = cur_next;
        result.ramping   = ramp_run_next;
        result.temporary = temp_next;
        result.error     = err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg         <= ST_OFF;
            saved_reg       <= ST_OFF;
            phase_reg       <= ACT_OFF_END;
            now_reg         <= '0;
            high_reg        <= LEVEL_FULL;
            low_reg         <= '0;
            temp_reg        <= 1'b0;
            dur_left_reg    <= '0;
            ramp_period_reg <= '0;
            ramp_left_reg   <= '0;
            ramp_run_reg    <= 1'b0;
            on_len_reg      <= '0;
            off_len_reg     <= '0;
            blink_left_reg  <= '0;
            blink_run_reg   <= 1'b0;
            used_reg        <= '0;
            pos_reg         <= '0;
            started_reg     <= 1'b0;
        end else if (fire) begin
            cur_reg         <= cur_next;
            saved_reg       <= saved_next;
            phase_reg       <= phase_next;
            now_reg         <= now_next;
            high_reg        <= high_next;
            low_reg         <= low_next;
            temp_reg        <= temp_next;
            dur_left_reg    <= dur_left_next;
            ramp_period_reg <= ramp_period_next;
            ramp_left_reg   <= ramp_left_next;
            ramp_run_reg    <= ramp_run_next;
            on_len_reg      <= on_len_next;
            off_len_reg     <= off_len_next;
            blink_left_reg  <= blink_left_next;
            blink_run_reg   <= blink_run_next;
            used_reg        <= used_next;
            pos_reg         <= pos_next;
            started_reg     <= started_next;
        end
    end

    // Pattern entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE_N; i++) begin
                store_reg[i] <= '0;
            end
        end else if (fire && store_we) begin
            store_reg[item.entry_index[SIDX_W-1:0]] <= item.duration_ms;
        end
    end

endmodule

// File: rtl/core/led_blink_ramp_controller_top.sv
// ============================================================================
// LED blink/ramp controller
// Turns on/off/blink/pattern commands and 1 ms ticks into an LED duty level.
// ============================================================================
// Usage:
//   Send one transaction per command or per 1 ms tick on the s_ channel
//   (s_valid/s_ready). Each accepted transaction yields exactly one result
//   transaction on the m_ channel (m_valid/m_ready): duty in per-mille, LED
//   state, ramp and temporary flags, and an error flag.
//   An accepted transaction waits in the input register until its result is
//   loaded into the result register and presented until taken. Throughput: one
//   transaction per cycle unless the receiver stalls; the full state update
//   for one transaction is one pass of logic between the input and result
//   registers. When the receiver stalls, the result register holds its
//   transaction and the input register takes one more before s_ready drops.
//   Configuration (active_low, dimmable) is written through cfg_we/cfg_index/
//   cfg_wdata; the user must write it only while no transaction is in flight;
//   the block does not enforce this. It applies to the next level computation.
//   Reset (aresetn low, synchronous) empties both registers, clears the
//   pattern entries and puts the LED off at level zero with the maximum level
//   at 1000 per-mille; no clearing pass is needed afterward.
// ============================================================================
`include "led_blink_ramp_controller_top_defines.svh"

module led_blink_ramp_controller_top #(
    parameter int PATTERN_DEPTH = lbr_pkg::DEF_PATTERN_DEPTH,
    parameter int TIME_BITS     = lbr_pkg::DEF_TIME_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [lbr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // command / tick channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lbr_pkg::MODE_W-1:0]      s_mode,
    input  logic [lbr_pkg::DUR_W-1:0]       s_duration_ms,
    input  logic [lbr_pkg::PCT_W-1:0]       s_level_pct,
    input  logic [lbr_pkg::DUR_W-1:0]       s_ramp_ms,
    input  logic [lbr_pkg::DUR_W-1:0]       s_blink_on_ms,
    input  logic [lbr_pkg::DUR_W-1:0]       s_blink_off_ms,
    input  logic [lbr_pkg::PCT_W-1:0]       s_blink_low_pct,
    input  logic [lbr_pkg::ENTRY_W-1:0]     s_entry_index,
    input  logic [lbr_pkg::CNT_W-1:0]       s_pattern_count,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lbr_pkg::LEVEL_W-1:0]     m_duty_pm,
    output logic [lbr_pkg::STATE_W-1:0]     m_led_state,
    output logic                            m_ramping,
    output logic                            m_temporary,
    output logic                            m_error
);
    import lbr_pkg::*;

    lbr_cfg_t    cfg_reg;
    lbr_item_t   s_item;
    lbr_item_t   item;
    logic        item_valid;
    logic        out_can_load;
    logic        advance;
    lbr_result_t core_result;
    lbr_result_t out_result;

    // Configuration registers; writes land without handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_low <= 1'b0;
            cfg_reg.dimmable   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ACTIVE_LOW: cfg_reg.active_low <= cfg_wdata[0];
                CFG_DIMMABLE:   cfg_reg.dimmable   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Gather the input ports into one transaction.
    assign s_item.mode          = s_mode;
    assign s_item.duration_ms   = s_duration_ms;
    assign s_item.level_pct     = s_level_pct;
    assign s_item.ramp_ms       = s_ramp_ms;
    assign s_item.blink_on_ms   = s_blink_on_ms;
    assign s_item.blink_off_ms  = s_blink_off_ms;
    assign s_item.blink_low_pct = s_blink_low_pct;
    assign s_item.entry_index   = s_entry_index;
    assign s_item.pattern_count = s_pattern_count;

    // Advance the held transaction whenever the result register has room.
    assign advance = item_valid && out_can_load;

    lbr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lbr_core #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .TIME_BITS     (TIME_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .fire    (advance),
        .item    (item),
        .result  (core_result)
    );

    lbr_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .result_in (core_result),
        .can_load  (out_can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .result    (out_result)
    );

    // Drive the result ports from the held transaction.
    assign m_duty_pm   = out_result.duty_pm;
    assign m_led_state = out_result.led_state;
    assign m_ramping   = out_result.ramping;
    assign m_temporary = out_result.temporary;
    assign m_error     = out_result.error;

    // An evaluated transaction always shows up on the result channel.
    `LBR_ASSERT_NEXT(a_advance_gives_result, advance, m_valid)
    // Never overwrite a result that the receiver has not taken.
    `LBR_ASSERT_SAME(a_no_overwrite, m_valid && !m_ready, !advance)
    // Duty never leaves the per-mille range.
    `LBR_ASSERT_SAME(a_duty_range, m_valid, m_duty_pm <= LEVEL_FULL)
    // A ramp only runs in the on or off state, never while blinking.
    `LBR_ASSERT_SAME(a_ramp_not_blink, m_valid && m_ramping, m_led_state != ST_BLINK)

endmodule

// File: sim/led_blink_ramp_controller_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// LED blink/ramp controller testbench
// Drives commands and 1 ms ticks through the s_ channel, tracks the expected
// duty, state and flags of every transaction in a scoreboard, and checks each
// m_ channel transaction against it under random idling and config changes.
// ============================================================================
module led_blink_ramp_controller_top_tb;
    import lbr_pkg::*;

    // Mode code with no command behind it; the block must report its state.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    // Long receiver hold, placed at this result count, to back the block up.
    localparam int HOLD_AT_RESULT = 250;
    localparam int HOLD_CYCLES    = 120;
    localparam int RANDOM_PER_PHASE = 180;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the LED controller state and the
    // expected result of every accepted transaction, oldest first.
    // ------------------------------------------------------------------------
    class duty_scoreboard;
        bit          cfg_active_low;
        bit          cfg_dimmable;
        led_state_t  cur_st;
        led_state_t  saved_st;
        phase_act_t  act;
        int unsigned lvl_now, lvl_hi, lvl_lo;
        bit          temp_on, ramp_on, blink_on;
        int unsigned dur_left, ramp_per, ramp_left;
        int unsigned blink_on_len, blink_off_len, blink_left;
        int unsigned entries [DEF_PATTERN_DEPTH];
        int unsigned pat_used, pat_pos;
        bit          pat_started;
        lbr_result_t expected_duty [$];
        int          mismatches;

        function new();
            cfg_active_low = 1'b0;
            cfg_dimmable   = 1'b1;
            cur_st         = ST_OFF;
            saved_st       = ST_OFF;
            act            = ACT_OFF_END;
            lvl_now        = 0;
            lvl_hi         = 1000;
            lvl_lo         = 0;
            foreach (entries[i]) entries[i] = 0;
            mismatches     = 0;
        endfunction

        function void set_cfg(cfg_index_t idx, bit val);
            if (idx == CFG_ACTIVE_LOW) cfg_active_low = val;
            else cfg_dimmable = val;
        endfunction

        function int unsigned pct_pm(int unsigned pct);
            int unsigned v;
            v = (pct > 100 ? 100 : pct) * 10;
            return cfg_active_low ? 1000 - v : v;
        endfunction

        function void stop_timers();
            blink_on = 1'b0;
            ramp_on  = 1'b0;
            temp_on  = 1'b0;
        endfunction

        function void arm_temp(int unsigned d);
            if (d > 0) begin
                temp_on  = 1'b1;
                saved_st = cur_st;
                dur_left = d;
            end
        endfunction

        function void level_cmd(bit going_on, int unsigned d, int unsigned pct,
                                int unsigned ramp);
            int unsigned lv;
            stop_timers();
            arm_temp(d);
            cur_st = going_on ? ST_ON : ST_OFF;
            if (ramp == 0 || !cfg_dimmable) begin
                act = going_on ? ACT_ON_END : ACT_OFF_END;
                if (!cfg_dimmable) lv = ((pct != 0) ^ cfg_active_low) ? 1000 : 0;
                else lv = pct_pm(pct);
                if (going_on) lvl_hi = lv;
                else lvl_lo = lv;
                lvl_now = lv;
            end else begin
                act       = going_on ? ACT_GOING_ON : ACT_GOING_OFF;
                ramp_on   = 1'b1;
                ramp_per  = ramp;
                ramp_left = ramp;
            end
        endfunction

        // Returns 1 when both blink times are zero; nothing changes then.
        function bit blink_cmd(int unsigned on_ms, int unsigned off_ms, int unsigned d,
                               bit keep, int unsigned hi_pct, int unsigned lo_pct);
            if (on_ms == 0 && off_ms == 0) return 1'b1;
            stop_timers();
            blink_on_len  = on_ms;
            blink_off_len = off_ms;
            arm_temp(d);
            cur_st = ST_BLINK;
            act    = ACT_ON_END;
            if (!keep) begin
                if (!cfg_dimmable) begin
                    lvl_hi = pct_pm(100);
                    lvl_lo = pct_pm(0);
                end else begin
                    lvl_hi = pct_pm(hi_pct);
                    lvl_lo = pct_pm(lo_pct);
                end
            end
            lvl_now    = lvl_hi;
            blink_on   = 1'b1;
            blink_left = blink_on_len;
            return 1'b0;
        endfunction

        // Even entries switch on, odd entries switch off, each for its time.
        function void pattern_advance();
            int unsigned v;
            if (pat_used == 0) return;
            if (!pat_started || pat_pos + 1 >= pat_used) pat_pos = 0;
            else pat_pos++;
            pat_started = 1'b1;
            v = entries[pat_pos % DEF_PATTERN_DEPTH];
            if (pat_pos % 2 == 0) level_cmd(1'b1, v, 100, 0);
            else level_cmd(1'b0, v, 0, 0);
        endfunction

        function void ramp_step();
            int         step, now_l, hi, lo;
            bit         up, done;
            phase_act_t fin;
            step  = lvl_hi / 10;
            now_l = lvl_now;
            hi    = lvl_hi;
            lo    = lvl_lo;
            done  = 1'b0;
            if (act == ACT_GOING_ON) begin
                up  = !cfg_active_low;
                fin = ACT_ON_END;
            end else if (act == ACT_GOING_OFF) begin
                up  = cfg_active_low;
                fin = ACT_OFF_END;
            end else begin
                ramp_on = 1'b0;
                return;
            end
            if (up) begin
                now_l += step;
                if (now_l >= hi) begin
                    now_l = hi;
                    done  = 1'b1;
                end
            end else begin
                now_l -= step;
                if (now_l <= lo) begin
                    now_l = lo;
                    done  = 1'b1;
                end
            end
            lvl_now = now_l;
            if (done) begin
                ramp_on = 1'b0;
                act     = fin;
            end else begin
                ramp_left = ramp_per;
            end
        endfunction

        function void blink_toggle();
            if (act == ACT_ON_END) begin
                lvl_now    = cfg_active_low ? lvl_hi : lvl_lo;
                act        = ACT_OFF_END;
                blink_left = blink_off_len;
            end else begin
                lvl_now    = cfg_active_low ? lvl_lo : lvl_hi;
                act        = ACT_ON_END;
                blink_left = blink_on_len;
            end
        endfunction

        // Temporary time ran out: restore the saved state or step the pattern.
        function bit duration_end();
            bit err;
            err = 1'b0;
            stop_timers();
            cur_st = saved_st;
            if (pat_used > 0) begin
                pattern_advance();
            end else if (cur_st == ST_OFF) begin
                lvl_now = lvl_lo;
                act     = ACT_OFF_END;
            end else if (cur_st == ST_ON) begin
                lvl_now = lvl_hi;
                act     = ACT_ON_END;
            end else begin
                err    = blink_cmd(blink_on_len, blink_off_len, 0, 1'b1, 0, 0);
                cur_st = ST_BLINK;
            end
            return err;
        endfunction

        function void note_item(lbr_item_t it);
            bit          err;
            lbr_result_t exp_res;
            err = 1'b0;
            case (it.mode)
                MODE_TICK: begin
                    // Ramp acts first, then blink, then the duration timer.
                    if (ramp_on) begin
                        if (ramp_left <= 1) ramp_step();
                        else ramp_left--;
                    end
                    if (blink_on) begin
                        if (blink_left <= 1) blink_toggle();
                        else blink_left--;
                    end
                    if (temp_on) begin
                        if (dur_left <= 1) err = duration_end();
                        else dur_left--;
                    end
                end
                MODE_ON:  level_cmd(1'b1, it.duration_ms, it.level_pct, it.ramp_ms);
                MODE_OFF: level_cmd(1'b0, it.duration_ms, it.level_pct, it.ramp_ms);
                MODE_BLINK: begin
                    err = blink_cmd(it.blink_on_ms, it.blink_off_ms, it.duration_ms,
                                    1'b0, it.level_pct, it.blink_low_pct);
                end
                MODE_BLINK_TIMES: begin
                    blink_on_len  = it.blink_on_ms;
                    blink_off_len = it.blink_off_ms;
                end
                MODE_LOAD_ENTRY: begin
                    if (it.entry_index < DEF_PATTERN_DEPTH)
                        entries[it.entry_index] = it.duration_ms;
                end
                MODE_START_PATTERN: begin
                    if (it.pattern_count > DEF_PATTERN_DEPTH) begin
                        err = 1'b1;
                    end else begin
                        pat_used    = it.pattern_count;
                        pat_started = 1'b0;
                        pat_pos     = 0;
                        pattern_advance();
                    end
                end
                default: ;
            endcase
            if (cfg_dimmable) exp_res.duty_pm = LEVEL_W'(lvl_now);
            else exp_res.duty_pm = (lvl_now >= 1000) ? LEVEL_FULL : '0;
            exp_res.led_state = cur_st;
            exp_res.ramping   = ramp_on;
            exp_res.temporary = temp_on;
            exp_res.error     = err;
            expected_duty.push_back(exp_res);
        endfunction

        function void field_check(string what, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(lbr_result_t got);
            lbr_result_t want;
            if (expected_duty.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual duty %0d",
                         $time, got.duty_pm);
                mismatches++;
                return;
            end
            want = expected_duty.pop_front();
            field_check("duty_pm",   want.duty_pm,   got.duty_pm);
            field_check("led_state", want.led_state, got.led_state);
            field_check("ramping",   want.ramping,   got.ramping);
            field_check("temporary", want.temporary, got.temporary);
            field_check("error",     want.error,     got.error);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn         = 1'b0;
    logic                 cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [MODE_W-1:0]    s_mode          = '0;
    logic [DUR_W-1:0]     s_duration_ms   = '0;
    logic [PCT_W-1:0]     s_level_pct     = '0;
    logic [DUR_W-1:0]     s_ramp_ms       = '0;
    logic [DUR_W-1:0]     s_blink_on_ms   = '0;
    logic [DUR_W-1:0]     s_blink_off_ms  = '0;
    logic [PCT_W-1:0]     s_blink_low_pct = '0;
    logic [ENTRY_W-1:0]   s_entry_index   = '0;
    logic [CNT_W-1:0]     s_pattern_count = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [LEVEL_W-1:0]   m_duty_pm;
    logic [STATE_W-1:0]   m_led_state;
    logic                 m_ramping;
    logic                 m_temporary;
    logic                 m_error;

    duty_scoreboard sb = new();
    bit send_quiet;
    bit recv_quiet;
    int items_sent;
    int results_seen;

    led_blink_ramp_controller_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_duration_ms   (s_duration_ms),
        .s_level_pct     (s_level_pct),
        .s_ramp_ms       (s_ramp_ms),
        .s_blink_on_ms   (s_blink_on_ms),
        .s_blink_off_ms  (s_blink_off_ms),
        .s_blink_low_pct (s_blink_low_pct),
        .s_entry_index   (s_entry_index),
        .s_pattern_count (s_pattern_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_duty_pm       (m_duty_pm),
        .m_led_state     (m_led_state),
        .m_ramping       (m_ramping),
        .m_temporary     (m_temporary),
        .m_error         (m_error)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly short times so timers actually run out; now and then full range.
    function automatic int unsigned short_ms();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 12);
    endfunction

    function automatic int unsigned some_pct();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                           : $urandom_range(0, 100);
    endfunction

    // Random transaction: fields start as noise, then the ones the chosen
    // command uses are shaped toward values that exercise the timers.
    function automatic lbr_item_t random_item();
        lbr_item_t it;
        int        pick;
        it.mode          = $urandom_range(0, 7);
        it.duration_ms   = $urandom_range(0, 65535);
        it.level_pct     = $urandom_range(0, 255);
        it.ramp_ms       = $urandom_range(0, 65535);
        it.blink_on_ms   = $urandom_range(0, 65535);
        it.blink_off_ms  = $urandom_range(0, 65535);
        it.blink_low_pct = $urandom_range(0, 255);
        it.entry_index   = $urandom_range(0, 7);
        it.pattern_count = $urandom_range(0, 15);
        pick = $urandom_range(0, 99);
        if (pick < 50)      it.mode = MODE_TICK;
        else if (pick < 58) it.mode = MODE_ON;
        else if (pick < 66) it.mode = MODE_OFF;
        else if (pick < 74) it.mode = MODE_BLINK;
        else if (pick < 79) it.mode = MODE_BLINK_TIMES;
        else if (pick < 87) it.mode = MODE_LOAD_ENTRY;
        else if (pick < 93) it.mode = MODE_START_PATTERN;
        if (it.mode != MODE_TICK && $urandom_range(0, 7) != 0) begin
            it.duration_ms   = ($urandom_range(0, 2) == 0) ? 0 : short_ms();
            it.ramp_ms       = ($urandom_range(0, 1) == 0) ? 0 : short_ms();
            it.blink_on_ms   = short_ms();
            it.blink_off_ms  = short_ms();
            it.level_pct     = some_pct();
            it.blink_low_pct = some_pct();
            if ($urandom_range(0, 4) != 0) it.pattern_count = $urandom_range(0, 8);
        end
        return it;
    endfunction

    // Offer one transaction and hold it until accepted. Valid stays high
    // straight into the next transaction when no gap is drawn.
    task automatic send_item(input lbr_item_t it);
        int gap;
        if ($urandom_range(0, 19) == 0) send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= it.mode;
        s_duration_ms   <= it.duration_ms;
        s_level_pct     <= it.level_pct;
        s_ramp_ms       <= it.ramp_ms;
        s_blink_on_ms   <= it.blink_on_ms;
        s_blink_off_ms  <= it.blink_off_ms;
        s_blink_low_pct <= it.blink_low_pct;
        s_entry_index   <= it.entry_index;
        s_pattern_count <= it.pattern_count;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic send_cmd(input logic [MODE_W-1:0] mode, input int unsigned dur,
                            input int unsigned pct, input int unsigned ramp,
                            input int unsigned bon, input int unsigned boff,
                            input int unsigned blow, input int unsigned idx,
                            input int unsigned cnt);
        lbr_item_t it;
        it.mode          = mode;
        it.duration_ms   = dur;
        it.level_pct     = pct;
        it.ramp_ms       = ramp;
        it.blink_on_ms   = bon;
        it.blink_off_ms  = boff;
        it.blink_low_pct = blow;
        it.entry_index   = idx;
        it.pattern_count = cnt;
        send_item(it);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_cmd(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    // Load a pattern of random length with short entries, start it and let it run.
    task automatic pattern_program();
        int n;
        n = $urandom_range(1, DEF_PATTERN_DEPTH);
        for (int k = 0; k < n; k++)
            send_cmd(MODE_LOAD_ENTRY,
                     ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                     0, 0, 0, 0, 0, k, 0);
        send_cmd(MODE_START_PATTERN, 0, 0, 0, 0, 0, 0, 0, n);
        send_ticks($urandom_range(8, 40));
    endtask

    // Start a ramp with a short step period and tick it toward its end.
    task automatic ramp_sequence();
        send_cmd(($urandom_range(0, 1) == 0) ? MODE_ON : MODE_OFF,
                 ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 30),
                 some_pct(), $urandom_range(1, 3), 0, 0, 0, 0, 0);
        send_ticks($urandom_range(5, 30));
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 12)      pattern_program();
            else if (pick < 24) ramp_sequence();
            else send_item(random_item());
        end
        s_valid <= 1'b0;
    endtask

    // Corner cases: clamping, ramps, blink errors and restore, pattern limits.
    task automatic directed_items();
        send_ticks(1);
        send_cmd(MODE_ON, 0, 100, 0, 0, 0, 0, 0, 0);
        send_cmd(MODE_ON, 0, 255, 0, 0, 0, 0, 0, 0);            // clamp to 100
        send_cmd(MODE_OFF, 0, 0, 2, 0, 0, 0, 0, 0);             // ramp down
        send_ticks(2);
        send_cmd(MODE_ON, 3, 37, 1, 0, 0, 0, 0, 0);             // temporary ramp up
        send_ticks(3);
        send_cmd(MODE_BLINK, 0, 80, 0, 0, 0, 10, 0, 0);         // both times zero
        send_cmd(MODE_BLINK, 0, 80, 0, 2, 1, 255, 0, 0);
        send_cmd(MODE_BLINK, 2, 60, 0, 1, 1, 5, 0, 0);          // temporary blink
        send_cmd(MODE_BLINK_TIMES, 0, 0, 0, 0, 0, 0, 0, 0);
        send_ticks(2);                                          // restore with no times
        send_cmd(MODE_LOAD_ENTRY, 2, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(MODE_LOAD_ENTRY, 1, 0, 0, 0, 0, 0, 1, 0);
        send_cmd(MODE_LOAD_ENTRY, 65535, 0, 0, 0, 0, 0, 7, 0);
        send_cmd(MODE_START_PATTERN, 0, 0, 0, 0, 0, 0, 0, 9);   // beyond depth
        send_cmd(MODE_START_PATTERN, 0, 0, 0, 0, 0, 0, 0, 2);
        send_ticks(3);
        send_cmd(MODE_START_PATTERN, 0, 0, 0, 0, 0, 0, 0, 0);   // leave pattern mode
        send_cmd(MODE_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(MODE_ON, 65535, 50, 65535, 65535, 65535, 255, 7, 15);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: draw a stall per result, with one long hold so the block
    // backs up and drops s_ready while the sender keeps offering.
    // ------------------------------------------------------------------------
    task automatic take_results();
        int          stall;
        lbr_result_t got;
        forever begin
            if ($urandom_range(0, 19) == 0) recv_quiet = !recv_quiet;
            stall = recv_quiet ? 0 : $urandom_range(0, 15);
            if (results_seen == HOLD_AT_RESULT) stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.duty_pm   = m_duty_pm;
            got.led_state = m_led_state;
            got.ramping   = m_ramping;
            got.temporary = m_temporary;
            got.error     = m_error;
            sb.check_result(got);
            results_seen++;
        end
    endtask

    // Write one config register; the enable drops on the following cycle.
    task automatic write_reg(input cfg_index_t idx, input bit val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_cfg(idx, val);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait until every expected result has been taken, then let the pipe settle.
    task automatic drain();
        while (sb.expected_duty.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, then config phases covering every polarity and
    // dimming combination, directed corners first, random traffic in each.
    // ------------------------------------------------------------------------
    initial begin
        bit phase_low [5]  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
        bit phase_dim [5]  = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            take_results();
        join_none
        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_ACTIVE_LOW, phase_low[p]);
            write_reg(CFG_DIMMABLE, phase_dim[p]);
            if (p == 0) directed_items();
            random_phase(RANDOM_PER_PHASE);
            drain();
        end
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
